// ----- rtl/rpp_pkg.sv -----
// Shared types, constants and helpers for the rotate/project point pipeline.
// No dependencies.
`default_nettype none
package rpp_pkg;

	localparam int COORD_W = 24;          // world coordinate width
	localparam int VEC_W   = 32;          // camera-space coordinate width
	localparam int PROD_W  = VEC_W + 17;  // coordinate times cos/sin
	localparam int SUM_W   = PROD_W + 1;
	localparam int FIXED_SHIFT = 14;      // cos/sin words are scaled by 2^14 = 16384
	localparam int GAIN_W  = 24;
	localparam int DEPTH_W = 24;
	localparam int DEN_W   = DEPTH_W + 8; // depth * 256
	localparam int NUM_W   = VEC_W + GAIN_W;
	localparam int QBITS   = 17;          // quotient bits kept before saturation
	localparam int REM_W   = DEN_W + QBITS;
	localparam int LANES   = 2;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 48;

	localparam logic [CFG_IDX_W-1:0] REG_YAW    = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PITCH  = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROLL   = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CAM_X  = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CAM_Y  = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CAM_Z  = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_CLIP   = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN   = 4'd7;

	typedef struct packed {
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
		logic signed [COORD_W-1:0] point_z;
	} point_t;

	typedef struct packed {
		logic signed [15:0] screen_x;
		logic signed [15:0] screen_y;
		logic               visible;
	} screen_t;

	// side info that rides along with the divider
	typedef struct packed {
		logic vis;
		logic neg_x;
		logic ovf_x;
		logic neg_y;
		logic ovf_y;
	} div_tag_t;

	function automatic logic signed [VEC_W-1:0] sat_vec(input logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] hi;
		logic signed [SUM_W-1:0] lo;
		hi = SUM_W'(64'sd2147483647);
		lo = -SUM_W'(64'sd2147483648);
		if (v > hi)
			return VEC_W'(hi);
		else if (v < lo)
			return VEC_W'(lo);
		else
			return VEC_W'(v);
	endfunction

endpackage
`default_nettype wire

// ----- rtl/rpp_rotate.sv -----
// One plane rotation: a' = a*c - b*s, b' = a*s + b*c, scaled and saturated.
// Two pipeline stages. Depends on rpp_pkg.
`default_nettype none
module rpp_rotate (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              en,
	input  wire logic                              vld_in,
	input  wire logic signed [rpp_pkg::VEC_W-1:0]  a_in,
	input  wire logic signed [rpp_pkg::VEC_W-1:0]  b_in,
	input  wire logic signed [rpp_pkg::VEC_W-1:0]  pass_in,
	input  wire logic signed [15:0]                cos_w,
	input  wire logic signed [16:0]                sin_w,
	output logic                                   vld_out,
	output logic signed [rpp_pkg::VEC_W-1:0]       a_out,
	output logic signed [rpp_pkg::VEC_W-1:0]       b_out,
	output logic signed [rpp_pkg::VEC_W-1:0]       pass_out
);
	import rpp_pkg::*;

	localparam logic signed [SUM_W-1:0] TRUNC_BIAS = SUM_W'((1 << FIXED_SHIFT) - 1);
	localparam logic signed [SUM_W-1:0] NO_BIAS    = '0;

	logic                      vld_s1;
	logic signed [PROD_W-1:0]  p_ac_s1, p_bs_s1, p_as_s1, p_bc_s1;
	logic signed [VEC_W-1:0]   pass_s1;
	logic signed [SUM_W-1:0]   sum_a, sum_b;
	logic signed [SUM_W-1:0]   q_a, q_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_out <= 1'b0;
		end else if (en) begin
			vld_s1  <= vld_in;
			vld_out <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_ac_s1 <= PROD_W'(a_in) * PROD_W'(cos_w);
			p_bs_s1 <= PROD_W'(b_in) * PROD_W'(sin_w);
			p_as_s1 <= PROD_W'(a_in) * PROD_W'(sin_w);
			p_bc_s1 <= PROD_W'(b_in) * PROD_W'(cos_w);
			pass_s1 <= pass_in;
		end
	end

	assign sum_a = SUM_W'(p_ac_s1) - SUM_W'(p_bs_s1);
	assign sum_b = SUM_W'(p_as_s1) + SUM_W'(p_bc_s1);

	// arithmetic shift with a bias on negative sums truncates toward zero
	assign q_a = (sum_a + (sum_a[SUM_W-1] ? TRUNC_BIAS : NO_BIAS)) >>> FIXED_SHIFT;
	assign q_b = (sum_b + (sum_b[SUM_W-1] ? TRUNC_BIAS : NO_BIAS)) >>> FIXED_SHIFT;

	always_ff @(posedge clk) begin
		if (en) begin
			a_out    <= sat_vec(q_a);
			b_out    <= sat_vec(q_b);
			pass_out <= pass_s1;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/rpp_divider.sv -----
// Pipelined restoring divider, one quotient bit per stage, two lanes sharing
// one divisor. Depends on rpp_pkg.
`default_nettype none
module rpp_divider (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             en,
	input  wire logic                             vld_in,
	input  wire logic [rpp_pkg::REM_W-1:0]        num_in [rpp_pkg::LANES],
	input  wire logic [rpp_pkg::DEN_W-1:0]        den_in,
	input  wire rpp_pkg::div_tag_t                tag_in,
	output logic                                  vld_out,
	output logic [rpp_pkg::QBITS-1:0]             quo_out [rpp_pkg::LANES],
	output rpp_pkg::div_tag_t                     tag_out
);
	import rpp_pkg::*;

	logic                 vld_q [QBITS];
	logic [DEN_W-1:0]     den_q [QBITS];
	div_tag_t             tag_q [QBITS];
	logic [REM_W-1:0]     rem_q [QBITS][LANES];
	logic [QBITS-1:0]     quo_q [QBITS][LANES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < QBITS; i++)
				vld_q[i] <= 1'b0;
		end else if (en) begin
			vld_q[0] <= vld_in;
			for (int i = 1; i < QBITS; i++)
				vld_q[i] <= vld_q[i-1];
		end
	end

	always_ff @(posedge clk) begin
		logic [REM_W-1:0] rem_p;
		logic [REM_W-1:0] sh;
		logic [QBITS-1:0] q_p;
		logic [DEN_W-1:0] d_p;
		if (en) begin
			for (int i = 0; i < QBITS; i++) begin
				d_p = (i == 0) ? den_in : den_q[i-1];
				den_q[i] <= d_p;
				tag_q[i] <= (i == 0) ? tag_in : tag_q[i-1];
				sh = REM_W'(d_p) << (QBITS - 1 - i);
				for (int l = 0; l < LANES; l++) begin
					rem_p = (i == 0) ? num_in[l] : rem_q[i-1][l];
					q_p   = (i == 0) ? '0 : quo_q[i-1][l];
					if (rem_p >= sh) begin
						rem_q[i][l] <= rem_p - sh;
						quo_q[i][l] <= q_p | (QBITS'(1) << (QBITS - 1 - i));
					end else begin
						rem_q[i][l] <= rem_p;
						quo_q[i][l] <= q_p;
					end
				end
			end
		end
	end

	assign vld_out = vld_q[QBITS-1];
	assign tag_out = tag_q[QBITS-1];
	always_comb begin
		for (int l = 0; l < LANES; l++)
			quo_out[l] = quo_q[QBITS-1][l];
	end

endmodule
`default_nettype wire

// ----- rtl/rotate_project_point.sv -----
// Top level of the rotate/project point pipeline: config registers, camera
// offset, three rotations, clip test, perspective divide. Uses rpp_pkg,
// rpp_rotate and rpp_divider.
//
// Takes one world point per clock while in_stall is low and gives one screen
// result per point, in order. Registers, in order: camera offset; multiply,
// then scale and saturate, in each of the three rotations; gain multiply,
// then range check; divider (one quotient bit per stage); output register.
// A stall on the output while out_valid is high freezes the whole pipeline;
// in_stall follows it in the same cycle. cfg_ready is always high; write
// registers only while no points are in flight.
`default_nettype none
module rotate_project_point #(
	parameter int VIEW_WIDTH  = 320,
	parameter int VIEW_HEIGHT = 240
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire rpp_pkg::point_t                      in_data,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output rpp_pkg::screen_t                          out_data,
	input  wire logic                                 cfg_valid,
	output logic                                      cfg_ready,
	input  wire logic [rpp_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [rpp_pkg::CFG_DATA_W-1:0]       cfg_data
);
	import rpp_pkg::*;

	localparam logic signed [18:0] CX = 19'(VIEW_WIDTH / 2);
	localparam logic signed [18:0] CY = 19'(VIEW_HEIGHT / 2);

	logic [31:0]          yaw_q, pitch_q, roll_q;
	logic [COORD_W-1:0]   cam_x_q, cam_y_q, cam_z_q;
	logic [47:0]          clip_q;
	logic [GAIN_W-1:0]    gain_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			yaw_q   <= 32'h4000_0000;
			pitch_q <= 32'h4000_0000;
			roll_q  <= 32'h4000_0000;
			cam_x_q <= '0;
			cam_y_q <= '0;
			cam_z_q <= '0;
			clip_q  <= 48'h7FFFFF_000001;
			gain_q  <= 24'd256;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_YAW:   yaw_q   <= cfg_data[31:0];
				REG_PITCH: pitch_q <= cfg_data[31:0];
				REG_ROLL:  roll_q  <= cfg_data[31:0];
				REG_CAM_X: cam_x_q <= cfg_data[23:0];
				REG_CAM_Y: cam_y_q <= cfg_data[23:0];
				REG_CAM_Z: cam_z_q <= cfg_data[23:0];
				REG_CLIP:  clip_q  <= cfg_data[47:0];
				REG_GAIN:  gain_q  <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	logic en;
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	// camera offset
	logic                      vld_s1;
	logic signed [VEC_W-1:0]   x_s1, y_s1, z_s1;
	logic signed [COORD_W:0]   dx, dy, dz;

	assign dx = $signed({in_data.point_x[COORD_W-1], in_data.point_x})
		- $signed({cam_x_q[COORD_W-1], cam_x_q});
	assign dy = $signed({in_data.point_y[COORD_W-1], in_data.point_y})
		- $signed({cam_y_q[COORD_W-1], cam_y_q});
	assign dz = $signed({in_data.point_z[COORD_W-1], in_data.point_z})
		- $signed({cam_z_q[COORD_W-1], cam_z_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (en)
			vld_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= VEC_W'(dx);
			y_s1 <= VEC_W'(dy);
			z_s1 <= VEC_W'(dz);
		end
	end

	// yaw uses the opposite sine sign of the other two steps
	logic signed [16:0] yaw_sin_n, pitch_sin, roll_sin;
	assign yaw_sin_n = -$signed({yaw_q[15], yaw_q[15:0]});
	assign pitch_sin = $signed({pitch_q[15], pitch_q[15:0]});
	assign roll_sin  = $signed({roll_q[15], roll_q[15:0]});

	logic                    vld_yaw, vld_pitch, vld_roll;
	logic signed [VEC_W-1:0] x_yaw, z_yaw, y_yaw;
	logic signed [VEC_W-1:0] y_pit, z_pit, x_pit;
	logic signed [VEC_W-1:0] x_rol, y_rol, z_rol;

	rpp_rotate u_yaw (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_in(vld_s1),
		.a_in(x_s1), .b_in(z_s1), .pass_in(y_s1),
		.cos_w($signed(yaw_q[31:16])), .sin_w(yaw_sin_n),
		.vld_out(vld_yaw), .a_out(x_yaw), .b_out(z_yaw), .pass_out(y_yaw)
	);

	rpp_rotate u_pitch (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_in(vld_yaw),
		.a_in(y_yaw), .b_in(z_yaw), .pass_in(x_yaw),
		.cos_w($signed(pitch_q[31:16])), .sin_w(pitch_sin),
		.vld_out(vld_pitch), .a_out(y_pit), .b_out(z_pit), .pass_out(x_pit)
	);

	rpp_rotate u_roll (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_in(vld_pitch),
		.a_in(x_pit), .b_in(y_pit), .pass_in(z_pit),
		.cos_w($signed(roll_q[31:16])), .sin_w(roll_sin),
		.vld_out(vld_roll), .a_out(x_rol), .b_out(y_rol), .pass_out(z_rol)
	);

	// clip test and gain multiply
	logic                    vis_c;
	logic [VEC_W-1:0]        mag_x, mag_y;
	logic                    vld_s2, vis_s2, neg_x_s2, neg_y_s2;
	logic [NUM_W-1:0]        num_x_s2, num_y_s2;
	logic [DEN_W-1:0]        den_s2;

	assign vis_c = (z_rol > 0)
		&& (z_rol >= $signed({8'b0, clip_q[23:0]}))
		&& (z_rol <= $signed({8'b0, clip_q[47:24]}));
	assign mag_x = x_rol[VEC_W-1] ? VEC_W'(-x_rol) : VEC_W'(x_rol);
	assign mag_y = y_rol[VEC_W-1] ? VEC_W'(-y_rol) : VEC_W'(y_rol);

	always_ff @(posedge clk) begin
		if (en) begin
			vis_s2   <= vis_c;
			neg_x_s2 <= x_rol[VEC_W-1];
			neg_y_s2 <= y_rol[VEC_W-1];
			num_x_s2 <= NUM_W'(mag_x) * NUM_W'(gain_q);
			num_y_s2 <= NUM_W'(mag_y) * NUM_W'(gain_q);
			den_s2   <= {z_rol[DEPTH_W-1:0], 8'b0};
		end
	end

	// quotient overflow check: |num| >= den * 2^QBITS saturates anyway
	logic                    vld_s3;
	logic [REM_W-1:0]        num_s3 [LANES];
	logic [DEN_W-1:0]        den_s3;
	div_tag_t                tag_s3;
	logic [NUM_W-1:0]        den_sh;

	assign den_sh = NUM_W'({den_s2, {QBITS{1'b0}}});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_roll;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			num_s3[0]    <= num_x_s2[REM_W-1:0];
			num_s3[1]    <= num_y_s2[REM_W-1:0];
			den_s3       <= den_s2;
			tag_s3.vis   <= vis_s2;
			tag_s3.neg_x <= neg_x_s2;
			tag_s3.neg_y <= neg_y_s2;
			tag_s3.ovf_x <= num_x_s2 >= den_sh;
			tag_s3.ovf_y <= num_y_s2 >= den_sh;
		end
	end

	logic             vld_div;
	logic [QBITS-1:0] quo [LANES];
	div_tag_t         tag_div;

	rpp_divider u_div (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_in(vld_s3),
		.num_in(num_s3), .den_in(den_s3), .tag_in(tag_s3),
		.vld_out(vld_div), .quo_out(quo), .tag_out(tag_div)
	);

	// center offset and saturation
	logic signed [18:0] qx, qy, sx, sy;
	logic signed [15:0] sx_sat, sy_sat;
	screen_t            res;

	assign qx = tag_div.ovf_x ? 19'sh20000 : $signed({2'b0, quo[0]});
	assign qy = tag_div.ovf_y ? 19'sh20000 : $signed({2'b0, quo[1]});
	assign sx = tag_div.neg_x ? CX - qx : CX + qx;
	assign sy = tag_div.neg_y ? CY + qy : CY - qy;
	assign sx_sat = (sx > 19'sd32767) ? 16'sh7FFF :
		(sx < -19'sd32768) ? 16'sh8000 : 16'(sx);
	assign sy_sat = (sy > 19'sd32767) ? 16'sh7FFF :
		(sy < -19'sd32768) ? 16'sh8000 : 16'(sy);

	always_comb begin
		res.visible  = tag_div.vis;
		res.screen_x = tag_div.vis ? sx_sat : '0;
		res.screen_y = tag_div.vis ? sy_sat : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (en)
			out_valid <= vld_div;
	end

	always_ff @(posedge clk) begin
		if (en)
			out_data <= res;
	end

endmodule
`default_nettype wire

// ----- tb/sv/rotate_project_point_tb.sv -----
// Self-checking testbench for rotate_project_point: streams world points under
// several register settings and checks every screen result against a predictor.
// Depends on rpp_pkg and the rotate_project_point RTL.
`timescale 1ns / 100ps
`default_nettype none

class screen_scoreboard;
	bit [31:0] yaw_cs, pitch_cs, roll_cs;
	bit [23:0] cam_x, cam_y, cam_z;
	bit [47:0] clip;
	bit [23:0] gain;
	rpp_pkg::screen_t pending[$];
	int mismatches;
	int checked;
	int visible_seen;

	function new();
		yaw_cs = 32'h4000_0000;
		pitch_cs = 32'h4000_0000;
		roll_cs = 32'h4000_0000;
		cam_x = '0;
		cam_y = '0;
		cam_z = '0;
		clip = 48'h7FFFFF_000001;
		gain = 24'd256;
		mismatches = 0;
		checked = 0;
		visible_seen = 0;
	endfunction

	function void write_reg(logic [rpp_pkg::CFG_IDX_W-1:0] idx, logic [47:0] d);
		case (idx)
			rpp_pkg::REG_YAW:   yaw_cs = d[31:0];
			rpp_pkg::REG_PITCH: pitch_cs = d[31:0];
			rpp_pkg::REG_ROLL:  roll_cs = d[31:0];
			rpp_pkg::REG_CAM_X: cam_x = d[23:0];
			rpp_pkg::REG_CAM_Y: cam_y = d[23:0];
			rpp_pkg::REG_CAM_Z: cam_z = d[23:0];
			rpp_pkg::REG_CLIP:  clip = d;
			rpp_pkg::REG_GAIN:  gain = d[23:0];
			default: ;
		endcase
	endfunction

	static function longint clamp(longint v, longint lo, longint hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	static function longint cosw(bit [31:0] w);
		return longint'($signed(w[31:16]));
	endfunction

	static function longint sinw(bit [31:0] w);
		return longint'($signed(w[15:0]));
	endfunction

	function void note_point(rpp_pkg::point_t p);
		longint x, y, z, c, s, nx, ny, nz, nearp, farp, den, qx, qy;
		rpp_pkg::screen_t e;
		x = longint'(p.point_x) - longint'($signed(cam_x));
		y = longint'(p.point_y) - longint'($signed(cam_y));
		z = longint'(p.point_z) - longint'($signed(cam_z));
		c = cosw(yaw_cs); s = sinw(yaw_cs);
		nx = clamp((x * c + z * s) / 16384, -64'sd2147483648, 64'sd2147483647);
		nz = clamp((-x * s + z * c) / 16384, -64'sd2147483648, 64'sd2147483647);
		x = nx; z = nz;
		c = cosw(pitch_cs); s = sinw(pitch_cs);
		ny = clamp((y * c - z * s) / 16384, -64'sd2147483648, 64'sd2147483647);
		nz = clamp((y * s + z * c) / 16384, -64'sd2147483648, 64'sd2147483647);
		y = ny; z = nz;
		c = cosw(roll_cs); s = sinw(roll_cs);
		nx = clamp((x * c - y * s) / 16384, -64'sd2147483648, 64'sd2147483647);
		ny = clamp((x * s + y * c) / 16384, -64'sd2147483648, 64'sd2147483647);
		x = nx; y = ny;
		nearp = longint'(clip[23:0]);
		farp = longint'(clip[47:24]);
		if (z <= 0 || z < nearp || z > farp) begin
			e = '0;
		end else begin
			den = z * 256;
			qx = clamp(160 + (x * longint'(gain)) / den, -32768, 32767);
			qy = clamp(120 - (y * longint'(gain)) / den, -32768, 32767);
			e.screen_x = qx[15:0];
			e.screen_y = qy[15:0];
			e.visible = 1'b1;
		end
		pending.push_back(e);
	endfunction

	function void check_result(rpp_pkg::screen_t r);
		rpp_pkg::screen_t e;
		if (pending.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result x=%0d y=%0d vis=%0b", r.screen_x, r.screen_y,
					r.visible);
			return;
		end
		e = pending.pop_front();
		checked++;
		if (e.visible) visible_seen++;
		if (r !== e) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch: exp x=%0d y=%0d vis=%0b, got x=%0d y=%0d vis=%0b",
					e.screen_x, e.screen_y, e.visible, r.screen_x, r.screen_y, r.visible);
		end
	endfunction
endclass

module rotate_project_point_tb;
	import rpp_pkg::*;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	point_t in_data;
	logic out_valid;
	logic out_stall;
	screen_t out_data;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	screen_scoreboard sb;
	bit idle_on;
	int cfg_writes;
	int points_sent;

	rotate_project_point u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	always @(posedge clk)
		if (arst_n && out_valid && !out_stall)
			sb.check_result(out_data);

	// receiver stall bursts
	initial begin
		int n;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (idle_on && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 5);
				out_stall = 1'b1;
				repeat (n - 1) @(negedge clk);
				@(negedge clk);
				out_stall = 1'b0;
			end
		end
	end

	task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [23:0] v_lo, logic [23:0] v_hi);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = {v_hi, v_lo};
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, {v_hi, v_lo});
		cfg_writes++;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// every expected result back, then let the pipeline settle
	task automatic drain();
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic send_point(point_t p);
		int n;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			n = $urandom_range(1, 5);
			@(negedge clk);
			in_valid = 1'b0;
			repeat (n - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid = 1'b1;
		in_data = p;
		do @(posedge clk); while (in_stall);
		sb.note_point(p);
		points_sent++;
	endtask

	task automatic end_burst();
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	function automatic logic [23:0] rnd24();
		return 24'($urandom);
	endfunction

	function automatic point_t gen_point();
		point_t p;
		int sh;
		if ($urandom_range(0, 3) == 0) begin
			p.point_x = rnd24();
			p.point_y = rnd24();
			p.point_z = rnd24();
		end else begin
			// near the camera, mostly in front of it
			sh = $urandom_range(4, 16);
			p.point_x = $signed(sb.cam_x) + $signed(24'($urandom) >>> (24 - sh));
			p.point_y = $signed(sb.cam_y) + $signed(24'($urandom) >>> (24 - sh));
			p.point_z = $signed(sb.cam_z) + 24'($urandom_range(0, 1 << sh));
		end
		return p;
	endfunction

	task automatic apply_setting(int kind);
		logic [23:0] junk;
		junk = rnd24();
		case (kind)
			0: begin
				write_cfg(REG_YAW, 24'h000000, {junk[23:8], 8'h40});
				write_cfg(REG_PITCH, 24'h000000, {junk[15:0], 8'h40});
				write_cfg(REG_ROLL, 24'h000000, 24'h000040);
				write_cfg(REG_CAM_X, 24'h000000, junk);
				write_cfg(REG_CAM_Y, 24'h000000, 24'h0);
				write_cfg(REG_CAM_Z, 24'h000000, 24'h0);
				write_cfg(REG_CLIP, 24'h000001, 24'h7FFFFF);
				write_cfg(REG_GAIN, 24'($urandom_range(256, 65536)), junk);
			end
			1: begin
				// extremes: max/min cos-sin, camera at minimum, near above far
				write_cfg(REG_YAW, 24'h7F8000, 24'h7F);
				write_cfg(REG_PITCH, 24'h807FFF, 24'h00);
				write_cfg(REG_ROLL, 24'hFF8000, 24'h7F);
				write_cfg(REG_CAM_X, 24'h800000, 24'h0);
				write_cfg(REG_CAM_Y, 24'h800000, 24'h0);
				write_cfg(REG_CAM_Z, 24'h800000, 24'h0);
				write_cfg(REG_CLIP, 24'h000100, 24'h000010);
				write_cfg(REG_GAIN, 24'hFFFFFF, 24'h0);
			end
			2: begin
				// extremes: camera at maximum, full depth range, max gain
				write_cfg(REG_YAW, 24'h7FFFFF, 24'hFF);
				write_cfg(REG_PITCH, 24'h008000, 24'h80);
				write_cfg(REG_ROLL, 24'h7FFF, 24'h7F);
				write_cfg(REG_CAM_X, 24'h7FFFFF, junk);
				write_cfg(REG_CAM_Y, 24'h7FFFFF, 24'h0);
				write_cfg(REG_CAM_Z, 24'h7FFFFF, 24'h0);
				write_cfg(REG_CLIP, 24'h000000, 24'hFFFFFF);
				write_cfg(REG_GAIN, 24'hFFFFFF, 24'h0);
			end
			3: begin
				// zero gain, single-depth window
				write_cfg(REG_GAIN, 24'h000000, junk);
				write_cfg(REG_CLIP, 24'h000040, 24'h000040);
				write_cfg(REG_CAM_X, 24'h0, 24'h0);
				write_cfg(REG_CAM_Y, 24'h0, 24'h0);
				write_cfg(REG_CAM_Z, 24'h0, 24'h0);
			end
			default: begin
				write_cfg(REG_YAW, rnd24(), rnd24());
				write_cfg(REG_PITCH, rnd24(), rnd24());
				write_cfg(REG_ROLL, rnd24(), rnd24());
				write_cfg(REG_CAM_X, 24'($signed(rnd24()) >>> 8), rnd24());
				write_cfg(REG_CAM_Y, 24'($signed(rnd24()) >>> 8), rnd24());
				write_cfg(REG_CAM_Z, 24'($signed(rnd24()) >>> 8), rnd24());
				write_cfg(REG_CLIP, 24'($urandom_range(0, 64)),
					24'($urandom_range(4096, 24'hFFFFFF)));
				write_cfg(REG_GAIN, 24'($urandom_range(0, 1 << 20)), rnd24());
			end
		endcase
		// indexes past the register file are ignored
		write_cfg(CFG_IDX_W'($urandom_range(8, 15)), rnd24(), rnd24());
	endtask

	initial begin
		point_t p;
		point_t dir[$];
		int kinds[7] = '{0, 4, 1, 2, 3, 4, 4};
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		idle_on = 1'b1;
		cfg_writes = 0;
		points_sent = 0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// directed points under the reset settings
		dir.push_back('{24'h000000, 24'h000000, 24'h000000});
		dir.push_back('{24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF});
		dir.push_back('{24'h800000, 24'h800000, 24'h800000});
		dir.push_back('{24'h7FFFFF, 24'h800000, 24'h000001});
		dir.push_back('{24'h800000, 24'h7FFFFF, 24'h000001});
		dir.push_back('{24'h000010, 24'hFFFFF0, 24'h000001});
		dir.push_back('{24'h000000, 24'h000000, 24'hFFFFFF});
		dir.push_back('{24'h000064, 24'h000032, 24'h000002});
		dir.push_back('{24'hFFFF9C, 24'hFFFFCE, 24'h000100});
		dir.push_back('{24'h123456, 24'hEDCBA9, 24'h7FFFFE});
		dir.push_back('{24'h555555, 24'hAAAAAA, 24'h555555});
		dir.push_back('{24'hAAAAAA, 24'h555555, 24'h2AAAAA});
		foreach (dir[i]) send_point(dir[i]);
		end_burst();

		foreach (kinds[ph]) begin
			drain();
			if (ph == 6) idle_on = 1'b0;
			apply_setting(kinds[ph]);
			for (int i = 0; i < 240; i++) begin
				p = gen_point();
				send_point(p);
			end
			end_burst();
		end
		drain();

		$display("%0d points checked (%0d visible) over %0d register writes",
			sb.checked, sb.visible_seen, cfg_writes);
		$display("settings covered identity, random angles, clip extremes and zero/max gain");
		if (sb.mismatches == 0 && sb.pending.size() == 0 && sb.checked == points_sent) begin
			$display("Testbench completed without errors");
		end else begin
			$display("%0d mismatches, %0d results missing", sb.mismatches, sb.pending.size());
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end
endmodule

`default_nettype wire

// ----- filelist.f -----
rtl/rpp_pkg.sv
rtl/rpp_rotate.sv
rtl/rpp_divider.sv
rtl/rotate_project_point.sv
tb/sv/rotate_project_point_tb.sv
